// ----- rtl/core/phtc_pkg.sv -----
// Shared types and constants of the PID heading turn controller.
package phtc_pkg;

	localparam int ANGLE_W   = 21;
	localparam int GAIN_W    = 24;
	localparam int TOL_W     = 15;
	localparam int SPEED_W   = 8;
	localparam int ERR_W     = 16;
	localparam int DIFF_W    = ANGLE_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;

	// Register reset values.
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd38011;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd98;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 24'd57016;
	localparam logic [TOL_W-1:0]  TOLERANCE_RST  = 15'd300;

	// Heading fold: k = floor((|d| + FOLD_BIAS) / FULL_TURN), done as
	// ((|d| + FOLD_BIAS) >> 5) * RECIP_1125 >> RECIP_1125_SH (exact in range).
	localparam int FULL_TURN      = 36000;
	localparam int FOLD_BIAS      = 17999;
	localparam int RECIP_1125     = 59653;
	localparam int RECIP_1125_SH  = 26;

	// Speed scaling: |total| >> 16, then / 100 by reciprocal, clamp at 100.
	localparam int SPEED_MAX      = 100;
	localparam int SPEED_SAT_LIM  = 10000;
	localparam int RECIP_100      = 41944;
	localparam int RECIP_100_SH   = 22;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic        [GAIN_W-1:0]  gain_t;
	typedef logic        [TOL_W-1:0]   tol_t;
	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic signed [ERR_W-1:0]   err_t;
	typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic        [CFG_DAT_W-1:0] cfg_dat_t;

	// Per-stage control carried down the pipeline.
	typedef struct packed {
		logic start;
		logic act;
		logic done;
	} ctl_t;

endpackage

// ----- rtl/core/phtc_in_if.sv -----
// Sample request channel: start flag and measured heading.
interface phtc_in_if;
	logic                 valid;
	logic                 ready;
	logic                 start_turn;
	phtc_pkg::angle_t     measured_angle;

	modport source (output valid, output start_turn, output measured_angle, input ready);
	modport sink   (input valid, input start_turn, input measured_angle, output ready);
endinterface

// ----- rtl/core/phtc_out_if.sv -----
// Drive command channel: wheel speeds and done flag.
interface phtc_out_if;
	logic                 valid;
	logic                 ready;
	phtc_pkg::speed_t     left_speed;
	phtc_pkg::speed_t     right_speed;
	logic                 done_res;

	modport source (output valid, output left_speed, output right_speed, output done_res,
		input ready);
	modport sink   (input valid, input left_speed, input right_speed, input done_res,
		output ready);
endinterface

// ----- rtl/core/phtc_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface phtc_cfg_if;
	logic                 valid;
	logic                 ready;
	phtc_pkg::cfg_idx_t   index;
	phtc_pkg::cfg_dat_t   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/phtc_fold.sv -----
// Two-stage heading error fold into [-18000, 18000] hundredths of a degree.
module phtc_fold (
	input  logic             clk,
	input  logic             en,
	input  phtc_pkg::angle_t target,
	input  phtc_pkg::angle_t measured,
	output phtc_pkg::err_t   err_s3
);
	import phtc_pkg::*;

	localparam int NUM_W  = DIFF_W + 1;
	localparam int NSH_W  = NUM_W - 5;
	localparam int QP_W   = NSH_W + 16;
	localparam int K_W    = 6;
	localparam int KF_W   = K_W + 16;

	logic signed [DIFF_W-1:0] diff;
	logic        [DIFF_W-1:0] mag;
	logic        [NUM_W-1:0]  num;
	logic        [NSH_W-1:0]  num_sh;
	logic        [QP_W-1:0]   qp;
	logic signed [DIFF_W-1:0] diff_s2;
	logic        [K_W-1:0]    k_s2;
	logic        [KF_W-1:0]   kf;
	logic signed [DIFF_W-1:0] folded;

	always_comb begin
		diff   = DIFF_W'(target) - DIFF_W'(measured);
		mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		num    = NUM_W'(mag) + NUM_W'(FOLD_BIAS);
		num_sh = num[NUM_W-1:5];
		qp     = QP_W'(num_sh) * QP_W'(RECIP_1125);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s2 <= diff;
			k_s2    <= qp[RECIP_1125_SH+K_W-1:RECIP_1125_SH];
		end
	end

	// Remove whole turns toward zero.
	always_comb begin
		kf     = KF_W'(k_s2) * KF_W'(FULL_TURN);
		folded = diff_s2[DIFF_W-1] ? diff_s2 + $signed(DIFF_W'(kf))
		                           : diff_s2 - $signed(DIFF_W'(kf));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s3 <= folded[ERR_W-1:0];
		end
	end

endmodule

// ----- rtl/core/phtc_scale.sv -----
// Scale the PID sum to a percent speed: truncate toward zero, clamp at 100.
module phtc_scale #(
	parameter int TOTAL_W = 59
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [TOTAL_W-1:0] total,
	output phtc_pkg::speed_t         speed
);
	import phtc_pkg::*;

	localparam int HI_W   = TOTAL_W - 16;
	localparam int MQ_W   = 14;
	localparam int PROD_W = MQ_W + 16;
	localparam int MAG_W  = 7;

	logic [TOTAL_W-1:0] mag;
	logic [HI_W-1:0]    hi;
	logic [MQ_W-1:0]    mq_s6;
	logic               sat_s6;
	logic               neg_s6;
	logic [PROD_W-1:0]  prod;
	logic [MAG_W-1:0]   quo;
	logic [MAG_W-1:0]   smag;

	always_comb begin
		mag = total[TOTAL_W-1] ? TOTAL_W'(-total) : TOTAL_W'(total);
		hi  = mag[TOTAL_W-1:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mq_s6  <= hi[MQ_W-1:0];
			sat_s6 <= hi >= HI_W'(SPEED_SAT_LIM);
			neg_s6 <= total[TOTAL_W-1];
		end
	end

	always_comb begin
		prod  = PROD_W'(mq_s6) * PROD_W'(RECIP_100);
		quo   = prod[RECIP_100_SH+MAG_W-1:RECIP_100_SH];
		smag  = sat_s6 ? MAG_W'(SPEED_MAX) : quo;
		speed = neg_s6 ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
	end

endmodule

// ----- rtl/core/pid_heading_turn_controller.sv -----
// Top level of the PID heading turn controller.
//
// Takes one gyro heading sample per request and returns one drive command
// per sample, in order. The pipeline accepts a new sample every clock cycle
// while the output is not stalled; a result waits in the output register
// until taken. A stalled output holds the whole pipeline, so the input
// ready drops only while a result sits unclaimed. The integral and
// last-error state is read and updated in a single stage, so back-to-back
// samples see each other's updates exactly. Stages: input register, fold
// quotient, folded error, state access and operand capture, gain products,
// sum, speed scaling, output register. Configuration writes are always taken
// and should only be issued while no sample is in flight.
module pid_heading_turn_controller #(
	parameter int INTEGRAL_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	phtc_in_if.sink     in_req,
	phtc_out_if.source  res,
	phtc_cfg_if.sink    cfg
);
	import phtc_pkg::*;

	localparam int IW      = INTEGRAL_WIDTH;
	localparam int HALF    = IW / 2;
	localparam int HI_W    = IW - HALF;
	localparam int DE_W    = ERR_W + 1;
	localparam int PP_W    = ERR_W + GAIN_W + 1;
	localparam int PD_W    = DE_W + GAIN_W + 1;
	localparam int PIH_W   = HI_W + GAIN_W + 1;
	localparam int PIL_W   = HALF + GAIN_W;
	localparam int TOTAL_W = ((IW + GAIN_W + 1 > PD_W) ? IW + GAIN_W + 1 : PD_W) + 2;

	// Configuration registers.
	angle_t target_q;
	gain_t  prop_gain_q;
	gain_t  integ_gain_q;
	gain_t  deriv_gain_q;
	tol_t   tolerance_q;

	// Controller state.
	logic signed [IW-1:0] error_sum_q;
	err_t                 last_error_q;
	logic                 turning_q;

	// Pipeline valids and control.
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_vld_q;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	ctl_t ctl_nxt;

	// Payload.
	angle_t               meas_s1;
	err_t                 err_s3;
	logic [ERR_W-1:0]     err_mag;
	logic                 in_band;
	err_t                 e_s4;
	logic signed [IW-1:0] es_s4;
	logic signed [DE_W-1:0] de_s4;
	logic signed [PP_W-1:0]  pp_s5;
	logic signed [PD_W-1:0]  pd_s5;
	logic signed [PIH_W-1:0] pih_s5;
	logic        [PIL_W-1:0] pil_s5;
	logic [TOTAL_W-1:0] t_pp, t_pd, t_pih, t_pil;
	logic signed [TOTAL_W-1:0] total;
	logic signed [IW:0]   acc_sum;
	logic signed [IW-1:0] acc_sat;
	speed_t speed;
	speed_t left_q, right_q;
	logic   done_q;

	// Advance whenever the output register is free or being drained.
	assign adv          = !out_vld_q || res.ready;
	assign in_req.ready = adv;
	assign cfg.ready    = 1'b1;

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= '0;
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			deriv_gain_q <= DERIV_GAIN_RST;
			tolerance_q  <= TOLERANCE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TARGET:     target_q     <= cfg.data[ANGLE_W-1:0];
				REG_PROP_GAIN:  prop_gain_q  <= cfg.data[GAIN_W-1:0];
				REG_INTEG_GAIN: integ_gain_q <= cfg.data[GAIN_W-1:0];
				REG_DERIV_GAIN: deriv_gain_q <= cfg.data[GAIN_W-1:0];
				REG_TOLERANCE:  tolerance_q  <= cfg.data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_req.valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			out_vld_q <= v_s6;
		end
	end

	// Stage 1: capture the sample.
	always_ff @(posedge clk) begin
		if (adv) begin
			meas_s1       <= in_req.measured_angle;
			ctl_s1.start  <= in_req.start_turn;
			ctl_s1.act    <= 1'b0;
			ctl_s1.done   <= 1'b0;
			ctl_s2        <= ctl_s1;
			ctl_s3        <= ctl_s2;
		end
	end

	// Stages 2 and 3: fold the heading error.
	phtc_fold u_fold (
		.clk      (clk),
		.en       (adv),
		.target   (target_q),
		.measured (meas_s1),
		.err_s3   (err_s3)
	);

	// Stage 3: tolerance check and state access.
	always_comb begin
		err_mag = err_s3[ERR_W-1] ? ERR_W'(-err_s3) : ERR_W'(err_s3);
		in_band = err_mag <= ERR_W'(tolerance_q);
		acc_sum = (IW+1)'(error_sum_q) + (IW+1)'(err_s3);
		if (acc_sum[IW] != acc_sum[IW-1]) begin
			acc_sat = acc_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
		end else begin
			acc_sat = acc_sum[IW-1:0];
		end
		ctl_nxt = '0;
		if (ctl_s3.start) begin
			ctl_nxt.done = in_band;
		end else if (turning_q) begin
			ctl_nxt.act  = 1'b1;
			ctl_nxt.done = in_band;
		end
	end

	// Update the integral, last error and turn flag at most once per sample, on start samples and while turning.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
			turning_q    <= 1'b0;
		end else if (adv && v_s3) begin
			if (ctl_s3.start) begin
				error_sum_q  <= '0;
				last_error_q <= err_s3;
				turning_q    <= !in_band;
			end else if (turning_q) begin
				error_sum_q  <= acc_sat;
				last_error_q <= err_s3;
				if (in_band) begin
					turning_q <= 1'b0;
				end
			end
		end
	end

	// Stage 4: capture operands with the state as this sample saw it.
	always_ff @(posedge clk) begin
		if (adv) begin
			e_s4   <= err_s3;
			es_s4  <= error_sum_q;
			de_s4  <= DE_W'(err_s3) - DE_W'(last_error_q);
			ctl_s4 <= ctl_nxt;
		end
	end

	// Stage 5: gain products; the integral product is split in two halves.
	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s5  <= e_s4 * $signed({1'b0, prop_gain_q});
			pd_s5  <= de_s4 * $signed({1'b0, deriv_gain_q});
			pih_s5 <= $signed(es_s4[IW-1:HALF]) * $signed({1'b0, integ_gain_q});
			pil_s5 <= PIL_W'(es_s4[HALF-1:0]) * PIL_W'(integ_gain_q);
			ctl_s5 <= ctl_s4;
		end
	end

	// Sum of the three terms at full precision.
	always_comb begin
		t_pp  = TOTAL_W'(pp_s5);
		t_pd  = TOTAL_W'(pd_s5);
		t_pih = TOTAL_W'(pih_s5) << HALF;
		t_pil = TOTAL_W'(pil_s5);
		total = $signed(t_pp + t_pd + t_pih + t_pil);
	end

	// Stage 6 inside: divide by 6553600 and clamp to the speed range.
	phtc_scale #(
		.TOTAL_W (TOTAL_W)
	) u_scale (
		.clk   (clk),
		.en    (adv),
		.total (total),
		.speed (speed)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s6 <= ctl_s5;
		end
	end

	// Output register: idle and start samples drive zero speed.
	always_ff @(posedge clk) begin
		if (adv) begin
			left_q  <= ctl_s6.act ? speed : '0;
			right_q <= ctl_s6.act ? -speed : '0;
			done_q  <= ctl_s6.done;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.left_speed  = left_q;
	assign res.right_speed = right_q;
	assign res.done_res    = done_q;

endmodule
